@@ design/gvn_pkg.sv @@
// Shared constants, types and codes of the grid vertex normal unit.
package gvn_pkg;

  // Grid limits and store geometry
  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);

  // Field widths
  localparam int IDX_W     = 14;
  localparam int POS_W     = 32;
  localparam int RES_W     = 8;
  localparam int NRM_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Datapath widths
  localparam int DIFF_W     = POS_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int ACC_W      = 68;
  localparam int VNORM_BITS = 30;
  localparam int SQ_W       = 2 * VNORM_BITS + 2;
  localparam int ROOT_W     = VNORM_BITS + 1;
  localparam int Q_FRAC     = 14;
  localparam int NUM_W      = VNORM_BITS + Q_FRAC + 1;
  localparam int QUO_W      = NRM_W;
  localparam int CS_W       = SQ_W + 1;
  localparam int CNT_W      = 6;
  localparam int SQRT_STEPS = SQ_W / 2 + 1;

  localparam logic [NRM_W-1:0] UNIT_Q14 = NRM_W'(1) << Q_FRAC;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_RES = 1'b0,
    CFG_Z_RES = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDIV,
    ST_READ,
    ST_MUL,
    ST_MDRAIN,
    ST_MAG,
    ST_NORM,
    ST_SQ,
    ST_SDRAIN,
    ST_SQRT,
    ST_DLOAD,
    ST_DIV,
    ST_OUT
  } gvn_state_e;

  typedef enum logic {
    MUL_CROSS  = 1'b0,
    MUL_SQUARE = 1'b1
  } mul_dest_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    vertex_t           data;
  } store_wr_t;

  typedef struct packed {
    logic       valid;
    mul_dest_e  dest;
    logic [1:0] comp;
    logic       sub;
  } mul_tag_t;

  typedef struct packed {
    logic            ge;
    logic [CS_W-1:0] diff;
  } cs_res_t;

endpackage

@@ design/grid_vertex_normals.sv @@
// Grid vertex normal unit: top level with sequencer and datapath registers.
//
// Holds a grid of Q16.16 vertex positions and returns the Q1.14 unit normal of a
// vertex as the normalised sum of the cross products of its up to four
// neighbouring triangles. A write transaction is stored without leaving the
// idle state, so the input stays unstalled. A query outside the grid in use
// gives a zero normal, going straight to the output state. A query inside the
// grid first splits the index into row and column one quotient bit a cycle,
// then makes five store reads through the single read port; each existing
// triangle needs six passes through the one multiplier, and the square root
// and the three component divisions run one bit a cycle on the shared
// compare/subtract unit. When the sum comes out zero the normalisation, root
// and divisions are skipped. While a query is in progress the input is
// stalled; the finished normal sits in an output register, so the next
// transaction is taken while it waits.
module grid_vertex_normals (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gvn_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gvn_pkg::RES_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [gvn_pkg::IDX_W-1:0]         vertex_index_i,
  input  logic signed [gvn_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [gvn_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [gvn_pkg::POS_W-1:0]  pos_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [gvn_pkg::NRM_W-1:0]  normal_x_o,
  output logic signed [gvn_pkg::NRM_W-1:0]  normal_y_o,
  output logic signed [gvn_pkg::NRM_W-1:0]  normal_z_o
);
  import gvn_pkg::*;

  localparam int IDX_SEL_W = $clog2(IDX_W);

  function automatic logic [1:0] next3(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prev3(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // Control state
  gvn_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       tri_q, tri_d;
  logic [1:0]       k_q, k_d;
  logic [RES_W-1:0] x_res_q, z_res_q;
  logic             out_valid_q, out_valid_d;

  // Datapath
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [RES_W-1:0]         drem_q, drem_d;
  logic [IDX_W-1:0]         iq_q, iq_d;
  vertex_t                  c_q, c_d;
  logic signed [DIFF_W-1:0] nb_q [4][3];
  logic signed [DIFF_W-1:0] nb_d [4][3];
  logic signed [ACC_W-1:0]  acc_q [3];
  logic signed [ACC_W-1:0]  acc_d [3];
  logic [ACC_W-1:0]         mag_q [3];
  logic [ACC_W-1:0]         mag_d [3];
  logic [2:0]               neg_q, neg_d;
  logic [SQ_W-1:0]          s_q, s_d;
  logic [CS_W-1:0]          r_q, r_d;
  logic [NUM_W-1:0]         rem_q, rem_d;
  logic [QUO_W-1:0]         quo_q, quo_d;
  logic signed [NRM_W-1:0]  res_q [3];
  logic signed [NRM_W-1:0]  res_d [3];
  logic signed [NRM_W-1:0]  out_n_q [3];
  logic signed [NRM_W-1:0]  out_n_d [3];

  // Combinational helpers
  logic                     in_accept;
  logic [RES_W-1:0]         xr, zr;
  logic [15:0]              grid_cells;
  logic [3:0]               tri_en;
  logic                     hb, ht, hr, hl;
  logic [ROOT_W-1:0]        root;
  logic [RES_W:0]           trial;
  logic [CS_W-1:0]          sq_bit;
  logic [ACC_W-1:0]         or_w;
  logic [VNORM_BITS-1:0]    vsel;
  logic [QUO_W-1:0]         quo_n;
  logic [QUO_W-1:0]         mag_n;
  logic [1:0]               kc;
  logic signed [ACC_W-1:0]  prod_ext;

  // Shared unit connections
  store_wr_t                st_wr;
  logic [ADDR_W-1:0]        rd_addr;
  vertex_t                  rd_data;
  mul_tag_t                 mul_tag_in, mul_tag_out;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_prod;
  logic [CS_W-1:0]          cs_a, cs_b;
  cs_res_t                  cs;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Resolution zero counts as one, above the limit saturates
  assign xr = (x_res_q == '0) ? RES_W'(1) :
              ((32'(x_res_q) > MAX_ROWS) ? RES_W'(MAX_ROWS) : x_res_q);
  assign zr = (z_res_q == '0) ? RES_W'(1) :
              ((32'(z_res_q) > MAX_COLS) ? RES_W'(MAX_COLS) : z_res_q);
  assign grid_cells = 16'(xr) * 16'(zr);

  // Neighbour presence from row iq_q and column drem_q
  assign hb = (9'(drem_q) + 9'd1) < 9'(zr);
  assign ht = (drem_q != '0);
  assign hr = (15'(iq_q) + 15'd1) < 15'(xr);
  assign hl = (iq_q != '0);
  assign tri_en = {hl & hb, ht & hl, hr & ht, hb & hr};

  assign root = r_q[ROOT_W-1:0];

  assign st_wr.en   = in_accept && (req_type_i == REQ_WRITE) &&
                      (32'(vertex_index_i) < DEPTH);
  assign st_wr.addr = ADDR_W'(vertex_index_i);
  assign st_wr.data = '{x: pos_x_i, y: pos_y_i, z: pos_z_i};

  gvn_store u_store (
    .clk_i     (clk_i),
    .wr_i      (st_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  gvn_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (mul_tag_in),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .tag_o  (mul_tag_out),
    .prod_o (mul_prod)
  );

  gvn_cmpsub u_cmpsub (
    .a_i   (cs_a),
    .b_i   (cs_b),
    .res_o (cs)
  );

  assign prod_ext = ACC_W'(mul_prod);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tri_d       = tri_q;
    k_d         = k_q;
    idx_d       = idx_q;
    drem_d      = drem_q;
    iq_d        = iq_q;
    c_d         = c_q;
    nb_d        = nb_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    s_d         = s_q;
    r_d         = r_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    res_d       = res_q;
    out_n_d     = out_n_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = ADDR_W'(idx_q);
    mul_tag_in  = '0;
    mul_a       = '0;
    mul_b       = '0;
    cs_a        = '0;
    cs_b        = '0;
    trial       = '0;
    sq_bit      = '0;
    or_w        = mag_q[0] | mag_q[1] | mag_q[2];
    vsel        = mag_q[k_q][VNORM_BITS-1:0];
    quo_n       = quo_q;
    mag_n       = '0;
    kc          = cnt_q[2:1];

    // Products land in the cycle after issue
    if (mul_tag_out.valid) begin
      if (mul_tag_out.dest == MUL_CROSS) begin
        if (mul_tag_out.sub) begin
          acc_d[mul_tag_out.comp] = acc_q[mul_tag_out.comp] - prod_ext;
        end else begin
          acc_d[mul_tag_out.comp] = acc_q[mul_tag_out.comp] + prod_ext;
        end
      end else begin
        s_d = s_q + SQ_W'(mul_prod[2*VNORM_BITS-1:0]);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept && (req_type_i == REQ_QUERY)) begin
          idx_d  = vertex_index_i;
          drem_d = '0;
          iq_d   = '0;
          cnt_d  = CNT_W'(IDX_W - 1);
          res_d  = '{default: '0};
          if (16'(vertex_index_i) < grid_cells) begin
            state_d = ST_IDIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end

      // Row/column split, one quotient bit a cycle
      ST_IDIV: begin
        trial = {drem_q, idx_q[cnt_q[IDX_SEL_W-1:0]]};
        cs_a  = CS_W'(trial);
        cs_b  = CS_W'(zr);
        if (cs.ge) begin
          drem_d = cs.diff[RES_W-1:0];
          iq_d[cnt_q[IDX_SEL_W-1:0]] = 1'b1;
        end else begin
          drem_d = trial[RES_W-1:0];
        end
        if (cnt_q == '0) begin
          state_d = ST_READ;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end

      // Reads: centre, bottom, right, top, left; data in the cycle after
      ST_READ: begin
        acc_d = '{default: '0};
        case (cnt_q)
          CNT_W'(1): rd_addr = ADDR_W'(idx_q) + ADDR_W'(1);
          CNT_W'(2): rd_addr = ADDR_W'(idx_q) + ADDR_W'(zr);
          CNT_W'(3): rd_addr = ADDR_W'(idx_q) - ADDR_W'(1);
          CNT_W'(4): rd_addr = ADDR_W'(idx_q) - ADDR_W'(zr);
          default:   rd_addr = ADDR_W'(idx_q);
        endcase
        if (cnt_q == CNT_W'(1)) begin
          c_d = rd_data;
        end
        if (cnt_q >= CNT_W'(2)) begin
          nb_d[2'(cnt_q - CNT_W'(2))][0] = DIFF_W'(rd_data.x) - DIFF_W'(c_q.x);
          nb_d[2'(cnt_q - CNT_W'(2))][1] = DIFF_W'(rd_data.y) - DIFF_W'(c_q.y);
          nb_d[2'(cnt_q - CNT_W'(2))][2] = DIFF_W'(rd_data.z) - DIFF_W'(c_q.z);
        end
        if (cnt_q == CNT_W'(5)) begin
          cnt_d   = '0;
          tri_d   = '0;
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      // Triangle t is neighbour t crossed with neighbour t+1
      ST_MUL: begin
        if (tri_en[tri_q]) begin
          mul_tag_in.valid = 1'b1;
          mul_tag_in.dest  = MUL_CROSS;
          mul_tag_in.comp  = kc;
          mul_tag_in.sub   = cnt_q[0];
          if (cnt_q[0]) begin
            mul_a = nb_q[tri_q][prev3(kc)];
            mul_b = nb_q[tri_q + 2'd1][next3(kc)];
          end else begin
            mul_a = nb_q[tri_q][next3(kc)];
            mul_b = nb_q[tri_q + 2'd1][prev3(kc)];
          end
        end
        if (!tri_en[tri_q] || (cnt_q == CNT_W'(5))) begin
          cnt_d = '0;
          if (tri_q == 2'd3) begin
            state_d = ST_MDRAIN;
          end else begin
            tri_d = tri_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      ST_MDRAIN: begin
        state_d = ST_MAG;
      end

      ST_MAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_d[k] = acc_q[k][ACC_W-1];
          mag_d[k] = acc_q[k][ACC_W-1] ? -acc_q[k] : acc_q[k];
        end
        s_d = '0;
        if ((acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_NORM;
        end
      end

      // Bring the largest magnitude to exactly VNORM_BITS bits
      ST_NORM: begin
        if (|or_w[ACC_W-1:VNORM_BITS+8]) begin
          for (int k = 0; k < 3; k++) mag_d[k] = mag_q[k] >> 8;
        end else if (|or_w[ACC_W-1:VNORM_BITS]) begin
          for (int k = 0; k < 3; k++) mag_d[k] = mag_q[k] >> 1;
        end else if (!(|or_w[VNORM_BITS-1:VNORM_BITS-8])) begin
          for (int k = 0; k < 3; k++) mag_d[k] = mag_q[k] << 8;
        end else if (!or_w[VNORM_BITS-1]) begin
          for (int k = 0; k < 3; k++) mag_d[k] = mag_q[k] << 1;
        end else begin
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end

      ST_SQ: begin
        mul_tag_in.valid = 1'b1;
        mul_tag_in.dest  = MUL_SQUARE;
        mul_a = DIFF_W'(mag_q[cnt_q[1:0]][VNORM_BITS-1:0]);
        mul_b = DIFF_W'(mag_q[cnt_q[1:0]][VNORM_BITS-1:0]);
        if (cnt_q == CNT_W'(2)) begin
          state_d = ST_SDRAIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      ST_SDRAIN: begin
        cnt_d   = CNT_W'(SQRT_STEPS - 1);
        r_d     = '0;
        state_d = ST_SQRT;
      end

      // Digit-by-digit integer root, bit walks down by two places
      ST_SQRT: begin
        sq_bit = CS_W'(1) << {cnt_q[4:0], 1'b0};
        cs_a   = CS_W'(s_q);
        cs_b   = r_q + sq_bit;
        if (cs.ge) begin
          s_d = cs.diff[SQ_W-1:0];
          r_d = (r_q >> 1) + sq_bit;
        end else begin
          r_d = r_q >> 1;
        end
        if (cnt_q == '0) begin
          k_d     = '0;
          state_d = ST_DLOAD;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end

      // Rounded numerator for the current component
      ST_DLOAD: begin
        rem_d   = NUM_W'({vsel, {Q_FRAC{1'b0}}}) + NUM_W'(root >> 1);
        quo_d   = '0;
        cnt_d   = CNT_W'(QUO_W - 1);
        state_d = ST_DIV;
      end

      ST_DIV: begin
        cs_a = CS_W'(rem_q);
        cs_b = CS_W'(root) << cnt_q[3:0];
        if (cs.ge) begin
          rem_d = cs.diff[NUM_W-1:0];
          quo_n[cnt_q[3:0]] = 1'b1;
        end
        quo_d = quo_n;
        if (cnt_q == '0) begin
          mag_n = (quo_n > UNIT_Q14) ? UNIT_Q14 : quo_n;
          res_d[k_q] = neg_q[k_q] ? $signed(NRM_W'(0) - mag_n) : $signed(mag_n);
          if (k_q == 2'd2) begin
            state_d = ST_OUT;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ST_DLOAD;
          end
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_n_d     = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tri_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      x_res_q     <= RES_W'(128);
      z_res_q     <= RES_W'(128);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tri_q       <= tri_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_X_RES) begin
          x_res_q <= cfg_wdata_i;
        end else begin
          z_res_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_d_dummy_guard: begin
      idx_q   <= idx_d;
      drem_q  <= drem_d;
      iq_q    <= iq_d;
      c_q     <= c_d;
      nb_q    <= nb_d;
      acc_q   <= acc_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      s_q     <= s_d;
      r_q     <= r_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      res_q   <= res_d;
      out_n_q <= out_n_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = out_n_q[0];
  assign normal_y_o  = out_n_q[1];
  assign normal_z_o  = out_n_q[2];

endmodule

@@ design/gvn_store.sv @@
// Vertex position store: one write port, one registered read port.
module gvn_store (
  input  logic                      clk_i,
  input  gvn_pkg::store_wr_t        wr_i,
  input  logic [gvn_pkg::ADDR_W-1:0] rd_addr_i,
  output gvn_pkg::vertex_t          rd_data_o
);
  import gvn_pkg::*;

  vertex_t mem_q [DEPTH];
  vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/gvn_mul.sv @@
// Shared signed multiplier with registered product and routing tag.
module gvn_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gvn_pkg::mul_tag_t                 tag_i,
  input  logic signed [gvn_pkg::DIFF_W-1:0] a_i,
  input  logic signed [gvn_pkg::DIFF_W-1:0] b_i,
  output gvn_pkg::mul_tag_t                 tag_o,
  output logic signed [gvn_pkg::PROD_W-1:0] prod_o
);
  import gvn_pkg::*;

  mul_tag_t                 tag_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign tag_o  = tag_q;
  assign prod_o = prod_q;

endmodule

@@ design/gvn_cmpsub.sv @@
// Shared compare/subtract step for index split, square root and division.
module gvn_cmpsub (
  input  logic [gvn_pkg::CS_W-1:0] a_i,
  input  logic [gvn_pkg::CS_W-1:0] b_i,
  output gvn_pkg::cs_res_t         res_o
);
  import gvn_pkg::*;

  logic [CS_W:0] diff_w;

  assign diff_w     = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~diff_w[CS_W];
  assign res_o.diff = diff_w[CS_W-1:0];

endmodule

@@ design/gvn_checker.sv @@
// Port-level checks for the grid vertex normal unit, bound to the top level.
module gvn_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             req_type_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [gvn_pkg::NRM_W-1:0] normal_x_o,
  input logic signed [gvn_pkg::NRM_W-1:0] normal_y_o,
  input logic signed [gvn_pkg::NRM_W-1:0] normal_z_o
);
  import gvn_pkg::*;

  localparam logic signed [NRM_W-1:0] NRM_MAX = NRM_W'(UNIT_Q14);
  localparam logic signed [NRM_W-1:0] NRM_MIN = -NRM_MAX;

  // Result transaction held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(normal_x_o) && $stable(normal_y_o) && $stable(normal_z_o))
    else $error("stalled result changed");

  // Clamp keeps every component within one unit
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (normal_x_o <= NRM_MAX) && (normal_x_o >= NRM_MIN) &&
      (normal_y_o <= NRM_MAX) && (normal_y_o >= NRM_MIN) &&
      (normal_z_o <= NRM_MAX) && (normal_z_o >= NRM_MIN))
    else $error("normal component out of range");

  // A write never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_WRITE) |=> !$rose(out_valid_o))
    else $error("result after write transaction");

  // A query occupies the sequencer
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_QUERY) |=> in_stall_o)
    else $error("input not stalled after query");

endmodule

bind grid_vertex_normals gvn_checker u_gvn_checker (.*);
